@@ sv/mcgd_pkg.sv @@
// ----------------------------------------------------------------------------
// mcgd_pkg
// Shared types and constants for the McGinley dynamic filter: item
// layouts, sequencer states and the divider request and response bundles.
// ----------------------------------------------------------------------------
package mcgd_pkg;

    // fixed-point format of samples and filter value
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int PERIOD_W = 24;

    // period register after reset: 10.0 in Q8.16
    localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(655360);

    // divider: two quotient bits per cycle over the full quotient width
    localparam int DIV_STEPS = (DATA_W + 1) / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // input item
    typedef struct packed {
        logic [DATA_W-1:0] sample;
        logic              batch_end;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [DATA_W-1:0] filtered;
        logic              div_error;
        logic              batch_end_out;
    } out_item_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RATIO,
        ST_SQ1,
        ST_SQ2,
        ST_SCALE,
        ST_CHECK,
        ST_STEP,
        ST_FINISH
    } seq_state_t;

    // divider request: (dividend << FRAC_W) / divisor
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    // divider response: done pulses for one cycle with the quotient
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ sv/mcginley_dynamic_filter.sv @@
// ----------------------------------------------------------------------------
// mcginley_dynamic_filter
// McGinley dynamic filter over unsigned Q16.16 samples, one result per item.
// ----------------------------------------------------------------------------
// Paths: the first item after reset, or any item while the filter is zero,
// goes straight to the hand-off; the rest take a division, three multiplies
// and the zero check, then, unless the denominator is zero, a second
// division before the hand-off; a saturating division ends without iterating.
// Flow: one item at a time; req_ready is high only while the sequencer is
// idle, and a stalled result holds the sequencer in its last state.
// Reset: filter cleared, not primed, period 10.0, no result pending.
module mcginley_dynamic_filter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            period_we,
    input  logic [mcgd_pkg::PERIOD_W-1:0]   period_wdata,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  mcgd_pkg::in_item_t              req_item,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output mcgd_pkg::out_item_t             rsp_item
);

    mcgd_pkg::seq_state_t state_reg, state_next;

    logic [mcgd_pkg::PERIOD_W-1:0] period_reg;
    logic [mcgd_pkg::DATA_W-1:0]   filter_reg, filter_next;
    logic                          primed_reg, primed_next;
    logic [mcgd_pkg::DATA_W-1:0]   sample_reg, sample_next;
    logic                          bend_reg, bend_next;
    logic [mcgd_pkg::DATA_W-1:0]   acc_reg, acc_next;
    logic [mcgd_pkg::PROD_W-1:0]   prod_reg;
    logic [mcgd_pkg::DATA_W-1:0]   res_reg, res_next;
    logic                          err_reg, err_next;
    logic                          out_valid_reg, out_valid_next;
    mcgd_pkg::out_item_t           out_item_reg, out_item_next;

    logic [mcgd_pkg::DATA_W-1:0] mul_a;
    logic [mcgd_pkg::DATA_W-1:0] mul_b;
    logic [mcgd_pkg::DATA_W-1:0] prod_sat;
    logic                        up;
    logic [mcgd_pkg::DATA_W-1:0] diff;
    logic [mcgd_pkg::DATA_W:0]   sum;
    logic                        req_fire;
    logic                        out_free;

    mcgd_pkg::div_req_t div_req;
    mcgd_pkg::div_rsp_t div_rsp;

    // shared divider
    mcgd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign req_ready = (state_reg == mcgd_pkg::ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign out_free  = !out_valid_reg || rsp_ready;

    // saturated Q16.16 view of the last product
    assign prod_sat = (|prod_reg[mcgd_pkg::PROD_W-1:mcgd_pkg::DATA_W+mcgd_pkg::FRAC_W])
                    ? '1 : prod_reg[mcgd_pkg::DATA_W+mcgd_pkg::FRAC_W-1:mcgd_pkg::FRAC_W];

    // distance between sample and filter, and its direction
    assign up   = sample_reg >= filter_reg;
    assign diff = up ? sample_reg - filter_reg : filter_reg - sample_reg;
    assign sum  = {1'b0, filter_reg} + {1'b0, div_rsp.quotient};

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            mcgd_pkg::ST_SQ1:
            begin
                mul_a = acc_reg;
                mul_b = acc_reg;
            end
            mcgd_pkg::ST_SQ2:
            begin
                mul_a = prod_sat;
                mul_b = prod_sat;
            end
            mcgd_pkg::ST_SCALE:
            begin
                mul_a = {{(mcgd_pkg::DATA_W-mcgd_pkg::PERIOD_W){1'b0}}, period_reg};
                mul_b = prod_sat;
            end
            mcgd_pkg::ST_IDLE,
            mcgd_pkg::ST_RATIO,
            mcgd_pkg::ST_CHECK,
            mcgd_pkg::ST_STEP,
            mcgd_pkg::ST_FINISH:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        filter_next    = filter_reg;
        primed_next    = primed_reg;
        sample_next    = sample_reg;
        bend_next      = bend_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_item_next  = out_item_reg;
        div_req        = '0;

        unique case (state_reg)
            mcgd_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    sample_next = req_item.sample;
                    bend_next   = req_item.batch_end;
                    if (!primed_reg)
                    begin
                        res_next   = req_item.sample;
                        err_next   = 1'b0;
                        state_next = mcgd_pkg::ST_FINISH;
                    end
                    else if (filter_reg == '0)
                    begin
                        res_next   = filter_reg;
                        err_next   = 1'b1;
                        state_next = mcgd_pkg::ST_FINISH;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = req_item.sample;
                        div_req.divisor  = filter_reg;
                        state_next       = mcgd_pkg::ST_RATIO;
                    end
                end
            end
            mcgd_pkg::ST_RATIO:
            begin
                if (div_rsp.done)
                begin
                    acc_next   = div_rsp.quotient;
                    state_next = mcgd_pkg::ST_SQ1;
                end
            end
            mcgd_pkg::ST_SQ1:
            begin
                state_next = mcgd_pkg::ST_SQ2;
            end
            mcgd_pkg::ST_SQ2:
            begin
                state_next = mcgd_pkg::ST_SCALE;
            end
            mcgd_pkg::ST_SCALE:
            begin
                state_next = mcgd_pkg::ST_CHECK;
            end
            mcgd_pkg::ST_CHECK:
            begin
                // zero denominator holds the filter
                if (prod_sat == '0)
                begin
                    res_next   = filter_reg;
                    err_next   = 1'b1;
                    state_next = mcgd_pkg::ST_FINISH;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = diff;
                    div_req.divisor  = prod_sat;
                    state_next       = mcgd_pkg::ST_STEP;
                end
            end
            mcgd_pkg::ST_STEP:
            begin
                if (div_rsp.done)
                begin
                    err_next = 1'b0;
                    if (up)
                        res_next = sum[mcgd_pkg::DATA_W] ? '1 : sum[mcgd_pkg::DATA_W-1:0];
                    else
                        res_next = (div_rsp.quotient > filter_reg)
                                 ? '0 : filter_reg - div_rsp.quotient;
                    state_next = mcgd_pkg::ST_FINISH;
                end
            end
            mcgd_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    filter_next                 = res_reg;
                    primed_next                 = 1'b1;
                    out_valid_next              = 1'b1;
                    out_item_next.filtered      = res_reg;
                    out_item_next.div_error     = err_reg;
                    out_item_next.batch_end_out = bend_reg;
                    state_next                  = mcgd_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcgd_pkg::ST_IDLE;
            period_reg    <= mcgd_pkg::PERIOD_RST;
            filter_reg    <= '0;
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            filter_reg    <= filter_next;
            primed_reg    <= primed_next;
            out_valid_reg <= out_valid_next;
            if (period_we)
                period_reg <= period_wdata;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        bend_reg     <= bend_next;
        acc_reg      <= acc_next;
        res_reg      <= res_next;
        err_reg      <= err_next;
        out_item_reg <= out_item_next;
        prod_reg     <= mul_a * mul_b;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_item_reg;

endmodule

@@ sv/mcgd_div.sv @@
// ----------------------------------------------------------------------------
// mcgd_div
// Iterative restoring divider computing (dividend << FRAC_W) / divisor,
// saturated to DATA_W bits, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module mcgd_div (
    input  logic              clk,
    input  logic              rst_n,
    input  mcgd_pkg::div_req_t req,
    output mcgd_pkg::div_rsp_t rsp
);

    logic [mcgd_pkg::DATA_W-1:0]    rem_reg;
    logic [mcgd_pkg::DATA_W-1:0]    sh_reg;
    logic [mcgd_pkg::DATA_W-1:0]    quo_reg;
    logic [mcgd_pkg::DATA_W-1:0]    dvs_reg;
    logic [mcgd_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [mcgd_pkg::DATA_W:0]   trial1;
    logic [mcgd_pkg::DATA_W:0]   trial2;
    logic                        ge1;
    logic                        ge2;
    logic [mcgd_pkg::DATA_W-1:0] rem1;
    logic [mcgd_pkg::DATA_W-1:0] rem2;
    logic                        sat;

    // quotient overflows when the integer part of the dividend reaches the divisor
    assign sat = {{(mcgd_pkg::DATA_W-mcgd_pkg::FRAC_W){1'b0}},
                  req.dividend[mcgd_pkg::DATA_W-1:mcgd_pkg::FRAC_W]} >= req.divisor;

    // two restoring steps; the remainder stays below the divisor
    always_comb
    begin
        trial1 = {rem_reg, sh_reg[mcgd_pkg::DATA_W-1]};
        ge1    = trial1 >= {1'b0, dvs_reg};
        rem1   = ge1 ? mcgd_pkg::DATA_W'(trial1 - {1'b0, dvs_reg})
                     : trial1[mcgd_pkg::DATA_W-1:0];
        trial2 = {rem1, sh_reg[mcgd_pkg::DATA_W-2]};
        ge2    = trial2 >= {1'b0, dvs_reg};
        rem2   = ge2 ? mcgd_pkg::DATA_W'(trial2 - {1'b0, dvs_reg})
                     : trial2[mcgd_pkg::DATA_W-1:0];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= !sat;
            done_reg <= sat;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg + 1'b1;
            busy_reg <= (cnt_reg != mcgd_pkg::DIV_LAST);
            done_reg <= (cnt_reg == mcgd_pkg::DIV_LAST);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvs_reg <= req.divisor;
            rem_reg <= {{(mcgd_pkg::DATA_W-mcgd_pkg::FRAC_W){1'b0}},
                        req.dividend[mcgd_pkg::DATA_W-1:mcgd_pkg::FRAC_W]};
            sh_reg  <= {req.dividend[mcgd_pkg::FRAC_W-1:0],
                        {(mcgd_pkg::DATA_W-mcgd_pkg::FRAC_W){1'b0}}};
            quo_reg <= sat ? '1 : '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem2;
            sh_reg  <= {sh_reg[mcgd_pkg::DATA_W-3:0], 2'b00};
            quo_reg <= {quo_reg[mcgd_pkg::DATA_W-3:0], ge1, ge2};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ sv/mcgd_checker.sv @@
// ----------------------------------------------------------------------------
// mcgd_checker
// Port-level checks for the McGinley dynamic filter, bound to the top level.
// ----------------------------------------------------------------------------
module mcgd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input mcgd_pkg::out_item_t rsp_item
);

    // one item in flight: ready drops after an accepted item
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready
    ) else $error("req_ready still high after an accepted item");

    // a result never appears in the cycle right after an item is taken
    a_no_instant_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid)
    ) else $error("result appeared too early after an accepted item");

    // a result only rises while req_ready is low or has just risen
    a_result_needs_item: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !req_ready || !$past(req_ready)
    ) else $error("result appeared while the block stayed idle");

    // a stalled result holds
    a_rsp_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item)
    ) else $error("stalled result changed or dropped");

endmodule

bind mcginley_dynamic_filter mcgd_checker u_mcgd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item)
);
